[sv/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
// Each module that asserts provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WHRMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition seen on one edge leads to another on the next.
`define WHRMS_ASSERT_NEXT(label, cond, next_cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (next_cond)) \
        else $error(msg);

`endif

[sv/whrms_pkg.sv]
`default_nettype none

package whrms_pkg;

    // Field widths of the beats and of the configuration port.
    localparam int ACT_W      = 2;
    localparam int OBJ_W      = 4;
    localparam int MISS_W     = 6;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int THR_W      = 9;
    localparam int KIND_W     = 3;
    localparam int HITS_W     = 6;
    localparam int DEPTH_CW   = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Action codes carried in the input tuser.
    localparam logic [ACT_W-1:0] ACT_CHECK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EXPIRE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PURGE  = 2'd2;

    // Switch kinds reported in the result.
    localparam logic [KIND_W-1:0] KIND_NONE           = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TO_AGGR        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TO_LAZY        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PERM_FROM_LAZY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PERM_FROM_AGGR = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TO_LAZY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TO_AGGR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERM_THR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERM_EN   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic check;
        logic purge;
        logic load;
        logic mod_step;
        logic fill_step;
        logic count_init;
        logic count_step;
        logic mult;
        logic decide;
        logic writeback;
        logic out_load;
    } whrms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic work;
        logic purge;
        logic idx_ge_depth;
        logic fill_done;
        logic eval_needed;
        logic count_done;
        logic out_free;
    } whrms_sts_t;

endpackage

`default_nettype wire

[sv/whrms_ram.sv]
`default_nettype none

module whrms_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/whrms_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"

module whrms_ctrl
    import whrms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire whrms_sts_t sts,
    output whrms_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_MOD,
        S_FILL,
        S_COUNT,
        S_MULT,
        S_DECIDE,
        S_WB,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.purge)
                begin
                    cmd.purge  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (sts.work)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (sts.idx_ge_depth)
                begin
                    cmd.mod_step = 1'b1;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (!sts.fill_done)
                begin
                    cmd.fill_step = 1'b1;
                end
                else if (sts.eval_needed)
                begin
                    cmd.count_init = 1'b1;
                    state_next     = S_COUNT;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_COUNT:
            begin
                if (sts.count_done)
                begin
                    state_next = S_MULT;
                end
                else
                begin
                    cmd.count_step = 1'b1;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `WHRMS_ASSERT_NEXT(a_accept_then_check, s_tvalid && s_tready, state_reg == S_CHECK, "accepted beat not classified next")
    `WHRMS_ASSERT(a_result_slot_free, cmd.out_load |-> sts.out_free, "result loaded over a waiting beat")

endmodule

`default_nettype wire

[sv/whrms_dp.sv]
`default_nettype none
`include "assert_macros.svh"

module whrms_dp
    import whrms_pkg::*;
#(
    parameter int NUM_OBJECTS = 16,
    parameter int MAX_WINDOW  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire whrms_cmd_t            cmd,
    output whrms_sts_t                 sts,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [ACT_W-1:0]      in_user,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data
);

    localparam int OW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int DW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PW = THR_W + DW;
    localparam int RW = POS_W + MAX_WINDOW;

    // Configuration registers.
    logic [DEPTH_CW-1:0] cfg_depth_reg;
    logic [THR_W-1:0]    cfg_lazy_reg;
    logic [THR_W-1:0]    cfg_aggr_reg;
    logic [THR_W-1:0]    cfg_perm_reg;
    logic                cfg_perm_en_reg;

    // Item and working registers.
    logic [ACT_W-1:0]      act_reg;
    logic [OBJ_W-1:0]      obj_reg;
    logic                  hit_reg;
    logic [MISS_W-1:0]     miss_reg;
    logic                  hit_pend_reg;
    logic [MAX_WINDOW-1:0] win_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [MAX_WINDOW-1:0] shift_reg;
    logic [DW-1:0]         count_rem_reg;
    logic [DW-1:0]         hits_reg;
    logic [PW-1:0]         scaled_reg;
    logic [PW-1:0]         prod_lazy_reg;
    logic [PW-1:0]         prod_aggr_reg;
    logic [PW-1:0]         prod_perm_reg;

    // Result registers.
    logic              res_suppress_reg;
    logic              res_eval_reg;
    logic [KIND_W-1:0] res_kind_reg;
    logic [DW-1:0]     res_hits_reg;

    // Per-object flags; an entry that is not valid reads as an empty window.
    logic [NUM_OBJECTS-1:0] valid_reg;
    logic [NUM_OBJECTS-1:0] mode_reg;
    logic [NUM_OBJECTS-1:0] perm_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [DW-1:0]     depth;
    logic [OW-1:0]     obj_idx;
    logic              obj_valid;
    logic              mode_cur;
    logic              perm_cur;
    logic              entry_valid;
    logic [RW-1:0]     ram_rdata;
    logic [CNT_W-1:0]  idx_inc;
    logic              mode_next;
    logic              perm_next;
    logic [KIND_W-1:0] kind_next;
    logic [POS_W-1:0]  pos_wb;

    always_comb
    begin
        if (cfg_depth_reg == '0)
        begin
            depth = DW'(1);
        end
        else if ({1'b0, cfg_depth_reg} > CNT_W'(MAX_WINDOW))
        begin
            depth = DW'(MAX_WINDOW);
        end
        else
        begin
            depth = DW'(cfg_depth_reg);
        end
    end

    assign obj_idx     = OW'(obj_reg);
    assign obj_valid   = (9'(obj_reg) < 9'(NUM_OBJECTS));
    assign mode_cur    = obj_valid && mode_reg[obj_idx];
    assign perm_cur    = obj_valid && perm_reg[obj_idx];
    assign entry_valid = obj_valid && valid_reg[obj_idx];
    assign idx_inc     = (idx_reg + CNT_W'(1) == CNT_W'(depth)) ? '0 : idx_reg + CNT_W'(1);
    assign pos_wb      = res_eval_reg ? '0 : cnt_reg[POS_W-1:0];

    assign sts.work = obj_valid
                    && ((act_reg == ACT_EXPIRE) || ((act_reg == ACT_CHECK) && !perm_cur));
    assign sts.purge        = (act_reg == ACT_PURGE);
    assign sts.idx_ge_depth = (idx_reg >= CNT_W'(depth));
    assign sts.fill_done    = !hit_pend_reg && (miss_reg == '0);
    assign sts.eval_needed  = (cnt_reg >= CNT_W'(depth));
    assign sts.count_done   = (count_rem_reg == '0);
    assign sts.out_free     = !out_valid_reg || out_ready;

    whrms_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_OBJECTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.writeback),
        .waddr (obj_idx),
        .wdata ({pos_wb, win_reg}),
        .re    (cmd.check),
        .raddr (obj_idx),
        .rdata (ram_rdata)
    );

    // Mode decision after an evaluation; the permanent threshold wins.
    always_comb
    begin
        mode_next = mode_cur;
        perm_next = perm_cur;
        kind_next = KIND_NONE;
        if (cfg_perm_en_reg && (scaled_reg < prod_perm_reg))
        begin
            if (!perm_cur)
            begin
                kind_next = mode_cur ? KIND_PERM_FROM_AGGR : KIND_PERM_FROM_LAZY;
            end
            mode_next = 1'b1;
            perm_next = 1'b1;
        end
        else if (!mode_cur && (scaled_reg < prod_aggr_reg))
        begin
            mode_next = 1'b1;
            kind_next = KIND_TO_AGGR;
        end
        else if (mode_cur && (scaled_reg > prod_lazy_reg))
        begin
            mode_next = 1'b0;
            kind_next = KIND_TO_LAZY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_depth_reg   <= DEPTH_CW'(32);
            cfg_lazy_reg    <= THR_W'(128);
            cfg_aggr_reg    <= THR_W'(64);
            cfg_perm_reg    <= THR_W'(16);
            cfg_perm_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEPTH:    cfg_depth_reg   <= cfg_wdata[DEPTH_CW-1:0];
                CFG_TO_LAZY:  cfg_lazy_reg    <= cfg_wdata;
                CFG_TO_AGGR:  cfg_aggr_reg    <= cfg_wdata;
                CFG_PERM_THR: cfg_perm_reg    <= cfg_wdata;
                CFG_PERM_EN:  cfg_perm_en_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mode_reg  <= '0;
            perm_reg  <= '0;
        end
        else
        begin
            if (cmd.purge)
            begin
                valid_reg <= '0;
            end
            else if (cmd.writeback)
            begin
                valid_reg[obj_idx] <= 1'b1;
            end
            if (cmd.decide)
            begin
                mode_reg[obj_idx] <= mode_next;
                perm_reg[obj_idx] <= perm_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg          <= in_user;
            obj_reg          <= in_data[OBJ_W-1:0];
            hit_reg          <= in_data[OBJ_W];
            miss_reg         <= in_data[OBJ_W+1 +: MISS_W];
            res_suppress_reg <= 1'b0;
            res_eval_reg     <= 1'b0;
            res_kind_reg     <= KIND_NONE;
            res_hits_reg     <= '0;
        end
        if (cmd.check)
        begin
            res_suppress_reg <= sts.work && (act_reg == ACT_CHECK) && hit_reg && !mode_cur;
        end
        if (cmd.load)
        begin
            win_reg      <= entry_valid ? ram_rdata[MAX_WINDOW-1:0] : '0;
            idx_reg      <= entry_valid ? CNT_W'(ram_rdata[MAX_WINDOW +: POS_W]) : '0;
            cnt_reg      <= entry_valid ? CNT_W'(ram_rdata[MAX_WINDOW +: POS_W]) : '0;
            hit_pend_reg <= (act_reg == ACT_CHECK) && hit_reg;
        end
        if (cmd.mod_step)
        begin
            idx_reg <= idx_reg - CNT_W'(depth);
        end
        if (cmd.fill_step)
        begin
            win_reg[idx_reg[IW-1:0]] <= hit_pend_reg;
            if (hit_pend_reg)
            begin
                hit_pend_reg <= 1'b0;
            end
            else
            begin
                miss_reg <= miss_reg - MISS_W'(1);
            end
            idx_reg <= idx_inc;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.count_init)
        begin
            shift_reg     <= win_reg;
            count_rem_reg <= depth;
            hits_reg      <= '0;
        end
        if (cmd.count_step)
        begin
            shift_reg     <= shift_reg >> 1;
            count_rem_reg <= count_rem_reg - DW'(1);
            hits_reg      <= hits_reg + DW'(shift_reg[0]);
        end
        if (cmd.mult)
        begin
            scaled_reg    <= PW'({hits_reg, 8'd0});
            prod_lazy_reg <= PW'(cfg_lazy_reg) * PW'(depth);
            prod_aggr_reg <= PW'(cfg_aggr_reg) * PW'(depth);
            prod_perm_reg <= PW'(cfg_perm_reg) * PW'(depth);
        end
        if (cmd.decide)
        begin
            res_eval_reg <= 1'b1;
            res_kind_reg <= kind_next;
            res_hits_reg <= hits_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= OUT_DATA_W'({HITS_W'(res_hits_reg), res_kind_reg, res_eval_reg,
                                         perm_cur, mode_cur, res_suppress_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WHRMS_ASSERT(a_fill_in_window, cmd.fill_step |-> (idx_reg < CNT_W'(depth)), "window write outside depth")
    `WHRMS_ASSERT(a_count_not_over, cmd.count_step |-> (count_rem_reg != '0), "hit count ran past depth")

endmodule

`default_nettype wire

[sv/windowed_hit_ratio_mode_selector_core.sv]
// Channel    Dir  Handshake                      Payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: object_id, hit, miss_count; tuser: action
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: suppress .. hits_in_window
// cfg        in   cfg_we (no back-pressure)      cfg_addr, cfg_wdata
//
// An item that records outcomes goes through window load, position reduction, outcome
// writes and write-back, plus hit counting, threshold products and the mode decision when
// the window is evaluated; other items go from classification to the result. The window
// writer stores one outcome per cycle, and the hit counter examines one window entry per cycle.
// Reset is asynchronous; per-object valid bits clear the windows at once, no clearing pass.
// A finished result waits in the output register while the next beat is accepted.
`default_nettype none

module windowed_hit_ratio_mode_selector_core
    import whrms_pkg::*;
#(
    parameter int NUM_OBJECTS = 16,
    parameter int MAX_WINDOW  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input beats.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // object_id[3:0], hit[4], miss_count[10:5]
    input  wire logic [ACT_W-1:0]      s_axis_tuser,  // action[1:0]
    // Result beats.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // suppress[0], mode[1], permanent[2],
                                                      // evaluated[3], switch_kind[6:4],
                                                      // hits_in_window[12:7]
    // Configuration writes.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // The controller sequences one item at a time through classification, window
    // load, position reduction, outcome writes, hit counting, threshold products,
    // the mode decision and write-back. The datapath holds the configuration, the
    // per-object window memory, the mode and permanent flags and the result register.
    whrms_cmd_t cmd;
    whrms_sts_t sts;

    whrms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    whrms_dp #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
